### sv/tpc_pkg.sv
package tpc_pkg;

  localparam int PERIM_W = 27;
  localparam int DIST_STAGES = 4;

  typedef logic [1:0] cls_t;

  localparam cls_t CLS_EQUI = 2'd0;
  localparam cls_t CLS_ISO  = 2'd1;
  localparam cls_t CLS_SCAL = 2'd2;

endpackage

### sv/tpc_dist.sv
module tpc_dist
  import tpc_pkg::*;
#(
  parameter int CB = 16
) (
  input  logic                 clk,
  input  logic                 en,
  input  logic signed [CB-1:0] ax,
  input  logic signed [CB-1:0] ay,
  input  logic signed [CB-1:0] bx,
  input  logic signed [CB-1:0] by,
  input  logic signed [CB-1:0] cx,
  input  logic signed [CB-1:0] cy,
  output logic [2*CB:0]        d0_o,
  output logic [2*CB:0]        d1_o,
  output logic [2*CB:0]        d2_o,
  output cls_t                 cls_o
);

  localparam int DW = 2 * CB + 1;

  function automatic logic [CB-1:0] abs_diff(input logic signed [CB-1:0] p,
                                             input logic signed [CB-1:0] q);
    logic signed [CB:0] df;
    logic [CB:0]        mag;
    df  = (CB+1)'(p) - (CB+1)'(q);
    mag = df[CB] ? (CB+1)'(-df) : df;
    return mag[CB-1:0];
  endfunction

  logic [CB-1:0]   ux_r [3];
  logic [CB-1:0]   uy_r [3];
  logic [2*CB-1:0] sx_r [3];
  logic [2*CB-1:0] sy_r [3];
  logic [DW-1:0]   d_r  [3];
  logic [DW-1:0]   dq_r [3];
  cls_t            cls_r;
  cls_t            cls_nxt;

  always_comb begin
    if (d_r[0] == d_r[1] && d_r[1] == d_r[2]) begin
      cls_nxt = CLS_EQUI;
    end else if (d_r[0] == d_r[1] || d_r[1] == d_r[2] || d_r[0] == d_r[2]) begin
      cls_nxt = CLS_ISO;
    end else begin
      cls_nxt = CLS_SCAL;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      ux_r[0] <= abs_diff(ax, bx);
      uy_r[0] <= abs_diff(ay, by);
      ux_r[1] <= abs_diff(bx, cx);
      uy_r[1] <= abs_diff(by, cy);
      ux_r[2] <= abs_diff(cx, ax);
      uy_r[2] <= abs_diff(cy, ay);
      for (int i = 0; i < 3; i++) begin
        sx_r[i] <= ux_r[i] * ux_r[i];
        sy_r[i] <= uy_r[i] * uy_r[i];
        d_r[i]  <= {1'b0, sx_r[i]} + {1'b0, sy_r[i]};
        dq_r[i] <= d_r[i];
      end
      cls_r <= cls_nxt;
    end
  end

  assign d0_o  = dq_r[0];
  assign d1_o  = dq_r[1];
  assign d2_o  = dq_r[2];
  assign cls_o = cls_r;

endmodule

### sv/tpc_sqrt.sv
module tpc_sqrt #(
  parameter int R = 25
) (
  input  logic           clk,
  input  logic           en,
  input  logic [2*R-1:0] op,
  output logic [R-1:0]   root
);

  localparam int W2 = 2 * R;
  localparam int RW = R + 2;

  logic [RW-1:0] rem_r  [R];
  logic [R-1:0]  root_r [R];
  logic [W2-1:0] opnd_r [R];

  for (genvar k = 0; k < R; k++) begin : g_stage
    logic [RW-1:0] rem_in;
    logic [R-1:0]  root_in;
    logic [W2-1:0] opnd_in;
    logic [RW-1:0] rem_sh;
    logic [RW-1:0] trial;
    logic          ge;
    logic [RW-1:0] rem_nxt;
    logic [R-1:0]  root_nxt;

    if (k == 0) begin : g_first
      assign rem_in  = '0;
      assign root_in = '0;
      assign opnd_in = op;
    end else begin : g_next
      assign rem_in  = rem_r[k-1];
      assign root_in = root_r[k-1];
      assign opnd_in = opnd_r[k-1];
    end

    assign rem_sh   = {rem_in[RW-3:0], opnd_in[W2-1-2*k -: 2]};
    assign trial    = {root_in, 2'b01};
    assign ge       = rem_sh >= trial;
    assign rem_nxt  = ge ? rem_sh - trial : rem_sh;
    assign root_nxt = {root_in[R-2:0], ge};

    always_ff @(posedge clk) begin
      if (en) begin
        rem_r[k]  <= rem_nxt;
        root_r[k] <= root_nxt;
        opnd_r[k] <= opnd_in;
      end
    end
  end

  assign root = root_r[R-1];

endmodule

### sv/triangle_perimeter_classifier_unit.sv
// Channel  Direction  Ports                                    Handshake
// in       input      in_ax in_ay in_bx in_by in_cx in_cy      in_valid / in_ready
// out      output     out_perimeter out_shape_class            out_valid / out_ready
//
// One word is taken per cycle while the output is not stalled; each word passes through the
// distance stages and then the square root, which resolves one root bit per stage.
// Reset clears only the valid bits; the data stages need none.
// A stall at the output freezes every stage at once, so nothing is lost or repeated.
module triangle_perimeter_classifier_unit
  import tpc_pkg::*;
#(
  parameter int COORD_BITS = 16,
  parameter int FRAC_BITS  = 8
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic signed [COORD_BITS-1:0] in_ax,
  input  logic signed [COORD_BITS-1:0] in_ay,
  input  logic signed [COORD_BITS-1:0] in_bx,
  input  logic signed [COORD_BITS-1:0] in_by,
  input  logic signed [COORD_BITS-1:0] in_cx,
  input  logic signed [COORD_BITS-1:0] in_cy,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic [PERIM_W-1:0]           out_perimeter,
  output logic [1:0]                   out_shape_class
);

  localparam int R   = COORD_BITS + 1 + FRAC_BITS;
  localparam int DW  = 2 * COORD_BITS + 1;
  localparam int W2  = 2 * R;
  localparam int LAT = DIST_STAGES + R;
  localparam int SUM_W = R + 2;
  localparam int SW  = (SUM_W > PERIM_W) ? SUM_W : PERIM_W;
  localparam logic [SW-1:0] LIMIT = SW'((64'd1 << PERIM_W) - 64'd1);

  logic               en;
  logic [LAT-1:0]     vld_r;
  logic               out_valid_r;
  logic [DW-1:0]      d0, d1, d2;
  cls_t               cls_d;
  cls_t               cls_r [R];
  logic [R-1:0]       root0, root1, root2;
  logic [SW-1:0]      sum;
  logic [PERIM_W-1:0] out_perimeter_r, out_perimeter_nxt;
  cls_t               out_shape_class_r;

  assign en       = !out_valid_r || out_ready;
  assign in_ready = en;

  tpc_dist #(.CB(COORD_BITS)) u_dist (
    .clk   (clk),
    .en    (en),
    .ax    (in_ax),
    .ay    (in_ay),
    .bx    (in_bx),
    .by    (in_by),
    .cx    (in_cx),
    .cy    (in_cy),
    .d0_o  (d0),
    .d1_o  (d1),
    .d2_o  (d2),
    .cls_o (cls_d)
  );

  tpc_sqrt #(.R(R)) u_sqrt0 (
    .clk  (clk),
    .en   (en),
    .op   (W2'(d0) << (2 * FRAC_BITS)),
    .root (root0)
  );

  tpc_sqrt #(.R(R)) u_sqrt1 (
    .clk  (clk),
    .en   (en),
    .op   (W2'(d1) << (2 * FRAC_BITS)),
    .root (root1)
  );

  tpc_sqrt #(.R(R)) u_sqrt2 (
    .clk  (clk),
    .en   (en),
    .op   (W2'(d2) << (2 * FRAC_BITS)),
    .root (root2)
  );

  assign sum = SW'(root0) + SW'(root1) + SW'(root2);
  assign out_perimeter_nxt = (sum > LIMIT) ? LIMIT[PERIM_W-1:0] : sum[PERIM_W-1:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r       <= '0;
      out_valid_r <= 1'b0;
    end else if (en) begin
      vld_r       <= {vld_r[LAT-2:0], in_valid};
      out_valid_r <= vld_r[LAT-1];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      cls_r[0] <= cls_d;
      for (int i = 1; i < R; i++) begin
        cls_r[i] <= cls_r[i-1];
      end
      out_perimeter_r   <= out_perimeter_nxt;
      out_shape_class_r <= cls_r[R-1];
    end
  end

  assign out_valid       = out_valid_r;
  assign out_perimeter   = out_perimeter_r;
  assign out_shape_class = out_shape_class_r;

endmodule
